FILE: rtl/amou_pkg.sv
// shared types and encoding constants for the atomic memory operation unit
package amou_pkg;

    // funct5 encodings of the atomic instructions
    localparam logic [4:0] F5_LR   = 5'h02;
    localparam logic [4:0] F5_SC   = 5'h03;
    localparam logic [4:0] F5_SWAP = 5'h01;
    localparam logic [4:0] F5_ADD  = 5'h00;
    localparam logic [4:0] F5_XOR  = 5'h04;
    localparam logic [4:0] F5_AND  = 5'h0c;
    localparam logic [4:0] F5_OR   = 5'h08;
    localparam logic [4:0] F5_MIN  = 5'h10;
    localparam logic [4:0] F5_MAX  = 5'h14;
    localparam logic [4:0] F5_MINU = 5'h18;
    localparam logic [4:0] F5_MAXU = 5'h1c;

    // funct3 access widths
    localparam logic [2:0] F3_WORD  = 3'd2;
    localparam logic [2:0] F3_DWORD = 3'd3;

    // access sizes in bytes
    localparam logic [3:0] SIZE_WORD  = 4'd4;
    localparam logic [3:0] SIZE_DWORD = 4'd8;

    // trap causes
    localparam logic [1:0] CAUSE_ILLEGAL = 2'd0;
    localparam logic [1:0] CAUSE_LOAD    = 2'd1;
    localparam logic [1:0] CAUSE_STORE   = 2'd2;

    // command codes
    localparam logic CMD_ATOMIC = 1'b0;
    localparam logic CMD_SNOOP  = 1'b1;

    typedef enum logic [3:0] {
        KIND_NONE,
        KIND_LR,
        KIND_SC,
        KIND_SWAP,
        KIND_ADD,
        KIND_XOR,
        KIND_AND,
        KIND_OR,
        KIND_MIN,
        KIND_MAX,
        KIND_MINU,
        KIND_MAXU
    } t_kind;

    // one input word
    typedef struct packed {
        logic        cmd;
        logic [31:0] instruction;
        logic [63:0] address;
        logic [63:0] operand;
        logic [63:0] mem_data;
        logic [3:0]  snoop_bytes;
    } t_item;

    // one result word
    typedef struct packed {
        logic        trap_valid;
        logic [1:0]  trap_cause;
        logic [63:0] trap_value;
        logic        rd_enable;
        logic [4:0]  rd_index;
        logic [63:0] rd_value;
        logic        store_enable;
        logic [63:0] store_data;
        logic        word_size;
    } t_result;

    // load reservation
    typedef struct packed {
        logic        valid;
        logic [63:0] address;
        logic [3:0]  size;
    } t_resv;

endpackage

FILE: rtl/amou_exec.sv
// decode, checks, amo arithmetic and reservation update for one word
module amou_exec #(
    parameter int PAGE_BYTES = 4096
) (
    input  amou_pkg::t_item   i_item,
    input  amou_pkg::t_resv   i_resv,
    output amou_pkg::t_result o_result,
    output amou_pkg::t_resv   o_resv_next
);
    import amou_pkg::*;

    localparam int PAGE_W = $clog2(PAGE_BYTES);

    t_kind       kind;
    logic [4:0]  f5;
    logic [2:0]  f3;
    logic [4:0]  rs2;
    logic        illegal;
    logic        is_word;
    logic [3:0]  acc_size;
    logic        misaligned;
    logic [3:0]  ov_size;
    logic [63:0] diff_ar;
    logic [63:0] diff_ra;
    logic        overlap;
    logic [PAGE_W:0] page_end;
    logic        page_cross;
    logic [63:0] op_a;
    logic [63:0] op_b;
    logic        lt_s;
    logic        lt_u;
    logic [63:0] amo_r;
    logic [63:0] load_val;
    logic        sc_match;

    assign f5  = i_item.instruction[31:27];
    assign f3  = i_item.instruction[14:12];
    assign rs2 = i_item.instruction[24:20];

    // funct5 decode
    always_comb begin
        case (f5)
            F5_LR:   kind = KIND_LR;
            F5_SC:   kind = KIND_SC;
            F5_SWAP: kind = KIND_SWAP;
            F5_ADD:  kind = KIND_ADD;
            F5_XOR:  kind = KIND_XOR;
            F5_AND:  kind = KIND_AND;
            F5_OR:   kind = KIND_OR;
            F5_MIN:  kind = KIND_MIN;
            F5_MAX:  kind = KIND_MAX;
            F5_MINU: kind = KIND_MINU;
            F5_MAXU: kind = KIND_MAXU;
            default: kind = KIND_NONE;
        endcase
    end

    // encoding and alignment checks
    assign illegal = (kind == KIND_NONE) || ((f3 != F3_WORD) && (f3 != F3_DWORD)) ||
                     ((kind == KIND_LR) && (rs2 != 5'd0));
    assign is_word    = (f3 == F3_WORD);
    assign acc_size   = is_word ? SIZE_WORD : SIZE_DWORD;
    assign misaligned = is_word ? (|i_item.address[1:0]) : (|i_item.address[2:0]);

    // byte range overlap with the reservation, shared by snoop and amo
    assign ov_size = (i_item.cmd == CMD_SNOOP) ? i_item.snoop_bytes : acc_size;
    assign diff_ar = i_item.address - i_resv.address;
    assign diff_ra = i_resv.address - i_item.address;
    always_comb begin
        if ((ov_size == 4'd0) || (i_resv.size == 4'd0)) begin
            overlap = 1'b0;
        end else if (i_item.address >= i_resv.address) begin
            overlap = (diff_ar[63:4] == 60'd0) && (diff_ar[3:0] < i_resv.size);
        end else begin
            overlap = (diff_ra[63:4] == 60'd0) && (diff_ra[3:0] < ov_size);
        end
    end

    // snooped store crossing a page boundary
    assign page_end   = {1'b0, i_item.address[PAGE_W-1:0]} +
                        (PAGE_W+1)'(i_item.snoop_bytes);
    assign page_cross = page_end > (PAGE_W+1)'(PAGE_BYTES);

    // amo operands, narrowed for word size
    assign op_a = is_word ? {32'd0, i_item.mem_data[31:0]} : i_item.mem_data;
    assign op_b = is_word ? {32'd0, i_item.operand[31:0]}  : i_item.operand;
    assign lt_s = is_word ? ($signed(op_a[31:0]) < $signed(op_b[31:0]))
                          : ($signed(op_a) < $signed(op_b));
    assign lt_u = op_a < op_b;

    // amo arithmetic
    always_comb begin
        case (kind)
            KIND_SWAP: amo_r = op_b;
            KIND_ADD:  amo_r = op_a + op_b;
            KIND_XOR:  amo_r = op_a ^ op_b;
            KIND_AND:  amo_r = op_a & op_b;
            KIND_OR:   amo_r = op_a | op_b;
            KIND_MIN:  amo_r = lt_s ? op_a : op_b;
            KIND_MAX:  amo_r = (!lt_s && (op_a != op_b)) ? op_a : op_b;
            KIND_MINU: amo_r = lt_u ? op_a : op_b;
            KIND_MAXU: amo_r = (!lt_u && (op_a != op_b)) ? op_a : op_b;
            default:   amo_r = op_a;
        endcase
    end

    // loaded value, sign-extended for word size
    assign load_val = is_word ? {{32{i_item.mem_data[31]}}, i_item.mem_data[31:0]}
                              : i_item.mem_data;

    assign sc_match = i_resv.valid && (i_resv.address == i_item.address) &&
                      (i_resv.size == acc_size);

    // result word and next reservation
    always_comb begin
        o_result    = '0;
        o_resv_next = i_resv;
        if (i_item.cmd == CMD_SNOOP) begin
            if ((i_item.snoop_bytes == 4'd0) || page_cross || overlap) begin
                o_resv_next.valid = 1'b0;
            end
        end else if (illegal) begin
            o_result.trap_valid = 1'b1;
            o_result.trap_cause = CAUSE_ILLEGAL;
            o_result.trap_value = {32'd0, i_item.instruction};
        end else begin
            o_result.word_size = is_word;
            if (misaligned) begin
                o_result.trap_valid = 1'b1;
                o_result.trap_cause = (kind == KIND_LR) ? CAUSE_LOAD : CAUSE_STORE;
                o_result.trap_value = i_item.address;
            end else begin
                o_result.rd_enable = 1'b1;
                o_result.rd_index  = i_item.instruction[11:7];
                case (kind)
                    KIND_LR: begin
                        o_resv_next.valid   = 1'b1;
                        o_resv_next.address = i_item.address;
                        o_resv_next.size    = acc_size;
                        o_result.rd_value   = load_val;
                    end
                    KIND_SC: begin
                        o_resv_next.valid = 1'b0;
                        if (sc_match) begin
                            o_result.store_enable = 1'b1;
                            o_result.store_data   = op_b;
                        end else begin
                            o_result.rd_value = 64'd1;
                        end
                    end
                    default: begin
                        o_result.store_enable = 1'b1;
                        o_result.store_data   = is_word ? {32'd0, amo_r[31:0]} : amo_r;
                        o_result.rd_value     = load_val;
                        if (i_resv.valid && overlap) begin
                            o_resv_next.valid = 1'b0;
                        end
                    end
                endcase
            end
        end
    end

endmodule

FILE: rtl/atomic_memory_op_unit.sv
// top level of the atomic memory operation unit: handshake, registers, reservation
//
// Executes one LR, SC or AMO instruction, or snoops one plain store, per input word.
// Input channel: i_in_valid / o_in_ready carry cmd, instruction, address, operand,
// mem_data and snoop_bytes. Output channel: o_out_valid / i_out_ready carry the
// trap, destination register and store fields of one result word.
// Every input word gives exactly one result word, in order.
// The input word is held in the input register, passes the execution logic and is
// then caught in the result register, which feeds the outputs. Throughput: one word
// per cycle while the receiver does not stall, set by the single combinational pass
// between the two registers; the reservation is read and written in that same pass,
// so back-to-back words see each other's updates.
// When the receiver stalls, the result register holds and the input register
// fills; o_in_ready then drops until the result is taken.
// Reset (i_rst_n low, synchronous) empties both registers and clears the
// reservation; o_in_ready stays low while reset is held.
// PAGE_BYTES is the page size in bytes, a power of two.
module atomic_memory_op_unit #(
    parameter int PAGE_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [31:0] i_instruction,
    input  logic [63:0] i_address,
    input  logic [63:0] i_operand,
    input  logic [63:0] i_mem_data,
    input  logic [3:0]  i_snoop_bytes,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_trap_valid,
    output logic [1:0]  o_trap_cause,
    output logic [63:0] o_trap_value,
    output logic        o_rd_enable,
    output logic [4:0]  o_rd_index,
    output logic [63:0] o_rd_value,
    output logic        o_store_enable,
    output logic [63:0] o_store_data,
    output logic        o_word_size
);
    import amou_pkg::*;

    logic    r_in_valid;
    logic    n_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_result;
    t_resv   r_resv;
    t_result exec_result;
    t_resv   exec_resv;
    logic    advance;

    // pipeline control
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = i_rst_n && (!r_in_valid || advance);
    assign n_in_valid  = i_in_valid || (r_in_valid && !advance);
    assign n_out_valid = advance || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_resv      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= n_in_valid;
            end
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_resv <= exec_resv;
            end
        end
    end

    // input word register
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.cmd         <= i_cmd;
            r_item.instruction <= i_instruction;
            r_item.address     <= i_address;
            r_item.operand     <= i_operand;
            r_item.mem_data    <= i_mem_data;
            r_item.snoop_bytes <= i_snoop_bytes;
        end
    end

    // execution pass
    amou_exec #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_exec (
        .i_item      (r_item),
        .i_resv      (r_resv),
        .o_result    (exec_result),
        .o_resv_next (exec_resv)
    );

    // result word register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= exec_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_trap_valid   = r_result.trap_valid;
    assign o_trap_cause   = r_result.trap_cause;
    assign o_trap_value   = r_result.trap_value;
    assign o_rd_enable    = r_result.rd_enable;
    assign o_rd_index     = r_result.rd_index;
    assign o_rd_value     = r_result.rd_value;
    assign o_store_enable = r_result.store_enable;
    assign o_store_data   = r_result.store_data;
    assign o_word_size    = r_result.word_size;

endmodule

FILE: dv/tb_atomic_memory_op_unit.sv
// self-checking testbench for the atomic memory operation unit with reservation tracking
module tb_atomic_memory_op_unit;
    import amou_pkg::*;

    localparam int PAGE_BYTES     = 4096;
    localparam int RANDOM_ITEMS   = 1450;
    localparam int RESET_CYCLES   = 10;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PRESSURE_ROUND = 40;
    localparam int PRESSURE_HOLD  = 300;
    localparam int REPORT_LIMIT   = 100;
    localparam logic [4:0] F5_UNUSED = 5'h1f;
    localparam logic [2:0] F3_BYTE   = 3'd0;

    // predicts each result word from the accepted words and checks the block against it
    class amo_result_tracker;
        t_resv       resv;
        t_result     pending_results[$];
        logic [63:0] page_bytes;
        int          mismatches;
        int          reports;

        function new(int page);
            resv       = '0;
            page_bytes = 64'(page);
            mismatches = 0;
            reports    = 0;
        endfunction

        function t_kind decode_kind(logic [4:0] f5);
            case (f5)
                F5_LR:   return KIND_LR;
                F5_SC:   return KIND_SC;
                F5_SWAP: return KIND_SWAP;
                F5_ADD:  return KIND_ADD;
                F5_XOR:  return KIND_XOR;
                F5_AND:  return KIND_AND;
                F5_OR:   return KIND_OR;
                F5_MIN:  return KIND_MIN;
                F5_MAX:  return KIND_MAX;
                F5_MINU: return KIND_MINU;
                F5_MAXU: return KIND_MAXU;
                default: return KIND_NONE;
            endcase
        endfunction

        function logic [63:0] sext_word(logic [31:0] v);
            return {{32{v[31]}}, v};
        endfunction

        // byte ranges [a, a+as) and [r, r+rs) share a byte
        function bit ranges_meet(logic [63:0] a, logic [63:0] as, logic [63:0] r,
                                 logic [63:0] rs);
            if (as == 0 || rs == 0) return 1'b0;
            return (a >= r) ? (a - r < rs) : (r - a < as);
        endfunction

        function void drop_on_overlap(logic [63:0] addr, logic [63:0] bytes);
            if (resv.valid && ranges_meet(addr, bytes, resv.address, 64'(resv.size)))
                resv.valid = 1'b0;
        endfunction

        // value written back to memory by a read-modify-write
        function logic [63:0] amo_value(t_kind kind, logic [63:0] loaded, logic [63:0] src,
                                        bit is_word);
            logic [63:0] a, b, res;
            bit          lt_s, lt_u;
            if (is_word) begin
                a    = {32'b0, loaded[31:0]};
                b    = {32'b0, src[31:0]};
                lt_s = $signed(loaded[31:0]) < $signed(src[31:0]);
            end else begin
                a    = loaded;
                b    = src;
                lt_s = $signed(loaded) < $signed(src);
            end
            lt_u = a < b;
            case (kind)
                KIND_SWAP: res = b;
                KIND_ADD:  res = a + b;
                KIND_XOR:  res = a ^ b;
                KIND_AND:  res = a & b;
                KIND_OR:   res = a | b;
                KIND_MIN:  res = lt_s ? a : b;
                KIND_MAX:  res = lt_s ? b : a;
                KIND_MINU: res = lt_u ? a : b;
                KIND_MAXU: res = lt_u ? b : a;
                default:   res = a;
            endcase
            return is_word ? {32'b0, res[31:0]} : res;
        endfunction

        // one accepted word in, one result word out, reservation updated
        function t_result execute_word(t_item w);
            t_result     r;
            t_kind       kind;
            logic [2:0]  f3;
            logic [4:0]  rs2;
            logic [3:0]  size;
            logic [63:0] page_off;
            bit          is_word;
            bit          sc_hit;
            r = '0;
            // snooped store: clear on empty size, page crossing or overlap
            if (w.cmd == CMD_SNOOP) begin
                page_off = w.address & (page_bytes - 64'd1);
                if (w.snoop_bytes == 0 || page_off + 64'(w.snoop_bytes) > page_bytes)
                    resv.valid = 1'b0;
                else
                    drop_on_overlap(w.address, 64'(w.snoop_bytes));
                return r;
            end
            kind = decode_kind(w.instruction[31:27]);
            f3   = w.instruction[14:12];
            rs2  = w.instruction[24:20];
            // illegal encoding
            if (kind == KIND_NONE || (f3 != F3_WORD && f3 != F3_DWORD) ||
                (kind == KIND_LR && rs2 != 5'd0)) begin
                r.trap_valid = 1'b1;
                r.trap_cause = CAUSE_ILLEGAL;
                r.trap_value = {32'b0, w.instruction};
                return r;
            end
            is_word     = (f3 == F3_WORD);
            size        = is_word ? SIZE_WORD : SIZE_DWORD;
            r.word_size = is_word;
            // misaligned access
            if ((w.address & (64'(size) - 64'd1)) != 0) begin
                r.trap_valid = 1'b1;
                r.trap_cause = (kind == KIND_LR) ? CAUSE_LOAD : CAUSE_STORE;
                r.trap_value = w.address;
                return r;
            end
            r.rd_enable = 1'b1;
            r.rd_index  = w.instruction[11:7];
            case (kind)
                KIND_LR: begin
                    resv.valid   = 1'b1;
                    resv.address = w.address;
                    resv.size    = size;
                    r.rd_value   = is_word ? sext_word(w.mem_data[31:0]) : w.mem_data;
                end
                KIND_SC: begin
                    sc_hit = resv.valid && resv.address == w.address && resv.size == size;
                    resv.valid = 1'b0;
                    if (sc_hit) begin
                        r.store_enable = 1'b1;
                        r.store_data   = is_word ? {32'b0, w.operand[31:0]} : w.operand;
                    end else begin
                        r.rd_value = 64'd1;
                    end
                end
                default: begin
                    r.store_enable = 1'b1;
                    r.store_data   = amo_value(kind, w.mem_data, w.operand, is_word);
                    r.rd_value     = is_word ? sext_word(w.mem_data[31:0]) : w.mem_data;
                    drop_on_overlap(w.address, 64'(size));
                end
            endcase
            return r;
        endfunction

        function void note_word(t_item w);
            pending_results.push_back(execute_word(w));
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                mismatches++;
                // keep the log readable when the block is badly broken
                if (reports < REPORT_LIMIT)
                    $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
                reports++;
            end
        endfunction

        function void check_word(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result word with nothing expected, got %h", $time, got);
                return;
            end
            want = pending_results.pop_front();
            compare_field("trap_valid",   64'(want.trap_valid),   64'(got.trap_valid));
            compare_field("trap_cause",   64'(want.trap_cause),   64'(got.trap_cause));
            compare_field("trap_value",   want.trap_value,        got.trap_value);
            compare_field("rd_enable",    64'(want.rd_enable),    64'(got.rd_enable));
            compare_field("rd_index",     64'(want.rd_index),     64'(got.rd_index));
            compare_field("rd_value",     want.rd_value,          got.rd_value);
            compare_field("store_enable", 64'(want.store_enable), 64'(got.store_enable));
            compare_field("store_data",   want.store_data,        got.store_data);
            compare_field("word_size",    64'(want.word_size),    64'(got.word_size));
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        i_cmd          = 1'b0;
    logic [31:0] i_instruction  = '0;
    logic [63:0] i_address      = '0;
    logic [63:0] i_operand      = '0;
    logic [63:0] i_mem_data     = '0;
    logic [3:0]  i_snoop_bytes  = '0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_trap_valid;
    logic [1:0]  o_trap_cause;
    logic [63:0] o_trap_value;
    logic        o_rd_enable;
    logic [4:0]  o_rd_index;
    logic [63:0] o_rd_value;
    logic        o_store_enable;
    logic [63:0] o_store_data;
    logic        o_word_size;
    t_result     seen_result;

    amo_result_tracker tracker;
    t_item             stimulus[$];

    atomic_memory_op_unit #(
        .PAGE_BYTES(PAGE_BYTES)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_instruction  (i_instruction),
        .i_address      (i_address),
        .i_operand      (i_operand),
        .i_mem_data     (i_mem_data),
        .i_snoop_bytes  (i_snoop_bytes),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_trap_valid   (o_trap_valid),
        .o_trap_cause   (o_trap_cause),
        .o_trap_value   (o_trap_value),
        .o_rd_enable    (o_rd_enable),
        .o_rd_index     (o_rd_index),
        .o_rd_value     (o_rd_value),
        .o_store_enable (o_store_enable),
        .o_store_data   (o_store_data),
        .o_word_size    (o_word_size)
    );

    assign seen_result = {o_trap_valid, o_trap_cause, o_trap_value, o_rd_enable, o_rd_index,
                          o_rd_value, o_store_enable, o_store_data, o_word_size};

    // clock
    always #5 i_clk = ~i_clk;

    // gap length: mostly none or short, now and then long
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // operand and memory values, biased towards sign and width edges
    function automatic logic [63:0] pick_data();
        case ($urandom_range(0, 9))
            0:       return 64'h0;
            1:       return 64'hFFFF_FFFF_FFFF_FFFF;
            2:       return 64'h8000_0000_0000_0000;
            3:       return 64'h7FFF_FFFF_FFFF_FFFF;
            4:       return {$urandom, 32'h8000_0000};
            5:       return {$urandom, 32'h7FFF_FFFF};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [2:0] pick_width();
        return $urandom_range(0, 1) ? F3_WORD : F3_DWORD;
    endfunction

    function automatic logic [3:0] pick_bytes();
        return ($urandom_range(0, 4) != 0) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(0, 15));
    endfunction

    // 0 lr, 1 sc, 2 to 10 read-modify-write kinds
    function automatic logic [4:0] op_code(int idx);
        case (idx)
            0:       return F5_LR;
            1:       return F5_SC;
            2:       return F5_SWAP;
            3:       return F5_ADD;
            4:       return F5_XOR;
            5:       return F5_AND;
            6:       return F5_OR;
            7:       return F5_MIN;
            8:       return F5_MAX;
            9:       return F5_MINU;
            default: return F5_MAXU;
        endcase
    endfunction

    function automatic void add_raw(logic cmd, logic [31:0] insn, logic [63:0] addr,
                                    logic [63:0] opnd, logic [63:0] mem, logic [3:0] bytes);
        t_item w;
        w.cmd         = cmd;
        w.instruction = insn;
        w.address     = addr;
        w.operand     = opnd;
        w.mem_data    = mem;
        w.snoop_bytes = bytes;
        stimulus.push_back(w);
    endfunction

    // unchecked instruction bits (ordering, rs1, opcode) are left random
    function automatic void add_atomic(logic [4:0] f5, logic [2:0] f3, logic [4:0] rs2,
                                       logic [4:0] rd, logic [63:0] addr, logic [63:0] opnd,
                                       logic [63:0] mem);
        add_raw(CMD_ATOMIC, {f5, 2'($urandom), rs2, 5'($urandom), f3, rd, 7'($urandom)},
                addr, opnd, mem, 4'($urandom));
    endfunction

    function automatic void add_snoop(logic [63:0] addr, logic [3:0] bytes);
        add_raw(CMD_SNOOP, $urandom, addr, {$urandom, $urandom}, {$urandom, $urandom}, bytes);
    endfunction

    // directed words: reservation life cycle, traps and every operation
    function automatic void build_directed();
        int i;
        // lr then sc to x0 and back, second sc finds nothing
        add_atomic(F5_LR, F3_DWORD, 5'd0, 5'd0, 64'h1000, pick_data(), 64'h8000_0000_0000_0001);
        add_atomic(F5_SC, F3_DWORD, 5'($urandom), 5'd0, 64'h1000, 64'hFFFF_FFFF_FFFF_FFFF,
                   pick_data());
        add_atomic(F5_SC, F3_DWORD, 5'($urandom), 5'd9, 64'h1000, pick_data(), pick_data());
        // word pair at the top of the address space, sign extension and zeroed upper half
        add_atomic(F5_LR, F3_WORD, 5'd0, 5'd31, 64'hFFFF_FFFF_FFFF_FFFC, pick_data(),
                   64'h1234_5678_8000_0000);
        add_atomic(F5_SC, F3_WORD, 5'($urandom), 5'd1, 64'hFFFF_FFFF_FFFF_FFFC,
                   64'hFFFF_FFFF_FFFF_FFFF, pick_data());
        // size mismatch fails the sc
        add_atomic(F5_LR, F3_WORD, 5'd0, 5'd2, 64'h0000_7FFF_FFFF_F000, pick_data(), pick_data());
        add_atomic(F5_SC, F3_DWORD, 5'($urandom), 5'd3, 64'h0000_7FFF_FFFF_F000, pick_data(),
                   pick_data());
        // illegal encodings
        add_atomic(F5_LR, F3_DWORD, 5'd5, 5'd4, 64'h1000, pick_data(), pick_data());
        add_atomic(F5_UNUSED, F3_WORD, 5'($urandom), 5'd4, 64'h1000, pick_data(), pick_data());
        add_atomic(F5_ADD, F3_BYTE, 5'($urandom), 5'd4, 64'h1000, pick_data(), pick_data());
        // misaligned load and store faults
        add_atomic(F5_LR, F3_WORD, 5'd0, 5'd5, 64'h1002, pick_data(), pick_data());
        add_atomic(F5_SC, F3_DWORD, 5'($urandom), 5'd5, 64'h1004, pick_data(), pick_data());
        // overlapping rmw kills the reservation
        add_atomic(F5_LR, F3_DWORD, 5'd0, 5'd6, 64'h2000, pick_data(), pick_data());
        add_atomic(F5_ADD, F3_WORD, 5'($urandom), 5'd7, 64'h2004, 64'h7FFF_FFFF,
                   64'h0000_0000_0000_0001);
        add_atomic(F5_SC, F3_DWORD, 5'($urandom), 5'd8, 64'h2000, pick_data(), pick_data());
        // one-byte snoop on the last reserved byte
        add_atomic(F5_LR, F3_DWORD, 5'd0, 5'd6, 64'h3008, pick_data(), pick_data());
        add_snoop(64'h300F, 4'd1);
        add_atomic(F5_SC, F3_DWORD, 5'($urandom), 5'd8, 64'h3008, pick_data(), pick_data());
        // page-crossing snoop elsewhere still clears
        add_atomic(F5_LR, F3_DWORD, 5'd0, 5'd10, 64'h4000, pick_data(), pick_data());
        add_snoop(64'h4FF8, 4'd15);
        add_atomic(F5_SC, F3_DWORD, 5'($urandom), 5'd11, 64'h4000, pick_data(), pick_data());
        // empty snoop clears
        add_atomic(F5_LR, F3_WORD, 5'd0, 5'd12, 64'h5000, pick_data(), pick_data());
        add_snoop(64'h9000, 4'd0);
        add_atomic(F5_SC, F3_WORD, 5'($urandom), 5'd13, 64'h5000, pick_data(), pick_data());
        // remaining rmw kinds with signed and unsigned order disagreeing
        for (i = 2; i <= 10; i++) begin
            if (op_code(i) != F5_ADD)
                add_atomic(op_code(i), (i % 2 == 0) ? F3_WORD : F3_DWORD, 5'($urandom),
                           5'(i), 64'h6000 + 64'(8 * i), 64'h7FFF_FFFF_8000_0000,
                           64'h8000_0000_7FFF_FFFF);
        end
    endfunction

    // random words: lr/sc sequences around one address, single operations, snoops and noise
    function automatic void build_random();
        logic [63:0] base, spot;
        logic [2:0]  f3, f3b;
        int          scen, extra, target;
        target = stimulus.size() + RANDOM_ITEMS;
        while (stimulus.size() < target) begin
            base = {$urandom, $urandom} & ~64'h7;
            if ($urandom_range(0, 3) == 0) base[11:0] = 12'hFF8;
            f3   = pick_width();
            scen = $urandom_range(0, 99);
            if (scen < 45) begin
                add_atomic(F5_LR, f3, 5'd0, 5'($urandom), base, pick_data(), pick_data());
                extra = $urandom_range(0, 2);
                repeat (extra) begin
                    if ($urandom_range(0, 1)) begin
                        f3b  = pick_width();
                        spot = base + 64'($urandom_range(0, 4) * 4) - 64'd8;
                        if (f3b == F3_DWORD) spot[2] = 1'b0;
                        add_atomic(op_code($urandom_range(2, 10)), f3b, 5'($urandom),
                                   5'($urandom), spot, pick_data(), pick_data());
                    end else begin
                        add_snoop(base + 64'($urandom_range(0, 23)) - 64'd12, pick_bytes());
                    end
                end
                add_atomic(F5_SC, ($urandom_range(0, 5) == 0) ? pick_width() : f3,
                           5'($urandom), 5'($urandom),
                           ($urandom_range(0, 5) == 0) ? (base ^ 64'h8) : base,
                           pick_data(), pick_data());
            end else if (scen < 75) begin
                add_atomic(op_code($urandom_range(0, 10)), f3,
                           ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'd0, 5'($urandom),
                           base, pick_data(), pick_data());
            end else if (scen < 88) begin
                spot = $urandom_range(0, 1) ? (base + 64'($urandom_range(0, 15)) - 64'd8)
                                            : {$urandom, 20'($urandom), 12'hFF0}
                                              + 64'($urandom_range(0, 15));
                add_snoop(spot, pick_bytes());
            end else if (scen < 95) begin
                add_raw(CMD_ATOMIC, $urandom, {$urandom, $urandom}, pick_data(), pick_data(),
                        4'($urandom));
            end else begin
                spot = base + 64'($urandom_range(1, 7));
                if (f3 == F3_WORD && spot[1:0] == 2'd0) spot[0] = 1'b1;
                add_atomic(op_code($urandom_range(0, 10)), f3, 5'd0, 5'($urandom), spot,
                           pick_data(), pick_data());
            end
        end
    endfunction

    // sender: offers each word and holds it until taken
    task automatic send_stream();
        int    gap;
        int    burst;
        t_item w;
        burst = 0;
        foreach (stimulus[i]) begin
            w = stimulus[i];
            if (burst > 0) begin
                gap = 0;
                burst--;
            end else begin
                gap = idle_gap();
                if ($urandom_range(0, 19) == 0) burst = $urandom_range(20, 60);
            end
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid    <= 1'b1;
            i_cmd         <= w.cmd;
            i_instruction <= w.instruction;
            i_address     <= w.address;
            i_operand     <= w.operand;
            i_mem_data    <= w.mem_data;
            i_snoop_bytes <= w.snoop_bytes;
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
            tracker.note_word(w);
        end
        i_in_valid <= 1'b0;
    endtask

    // receiver: random back-pressure, one long hold-off to fill the block
    initial begin
        int round;
        int hold;
        int gap;
        round = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (round == PRESSURE_ROUND) begin
                i_out_ready <= 1'b0;
                repeat (PRESSURE_HOLD) @(posedge i_clk);
            end
            hold = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
            gap  = idle_gap();
            i_out_ready <= 1'b1;
            repeat (hold) @(posedge i_clk);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            round++;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_word(seen_result);
    end

    // main sequence
    initial begin
        tracker = new(PAGE_BYTES);
        build_directed();
        build_random();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_stream();
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #10000000;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: atomic_memory_op_unit.f
rtl/amou_pkg.sv
rtl/amou_exec.sv
rtl/atomic_memory_op_unit.sv
dv/tb_atomic_memory_op_unit.sv
